@@ rtl/aes128_pkg.sv @@
// ----------------------------------------------------------------------------
// aes128_pkg: shared types, constants and GF(2^8) helpers for the AES-128 engine
// ----------------------------------------------------------------------------
`default_nettype none
package aes128_pkg;

  localparam int ROUNDS     = 10;
  localparam int KEY_HALVES = 2 * (ROUNDS + 1);
  localparam int SLOT_W     = 5;
  localparam int RND_W      = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ENCRYPT = 2'd1,
    ACT_DECRYPT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef logic [127:0] state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = i[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
  endfunction

  // byte i of the state, byte 0 in the top bits
  function automatic logic [7:0] sb(input state_t s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic state_t sub_shift(input state_t s);
    state_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*c+r) -: 8] = SBOX[sb(s, 4*((c+r)%4)+r)];
      end
    end
    return o;
  endfunction

  function automatic state_t inv_shift_sub(input state_t s);
    state_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*c+r) -: 8] = inv_sbox(sb(s, 4*((c+4-r)%4)+r));
      end
    end
    return o;
  endfunction

  function automatic state_t mix(input state_t s);
    state_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      o[127 - 8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[127 - 8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[127 - 8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  // inverse mix: pre-multiply by {04}x^2+{05} then apply forward mix
  function automatic state_t inv_mix(input state_t s);
    state_t p;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      p[127 - 8*(4*c)   -: 8] = a0 ^ u;
      p[127 - 8*(4*c+1) -: 8] = a1 ^ v;
      p[127 - 8*(4*c+2) -: 8] = a2 ^ u;
      p[127 - 8*(4*c+3) -: 8] = a3 ^ v;
    end
    return mix(p);
  endfunction

endpackage
`default_nettype wire

@@ rtl/aes128_block_cipher.sv @@
// ----------------------------------------------------------------------------
// aes128_block_cipher: iterative AES-128 encrypt/decrypt engine
// ----------------------------------------------------------------------------
// Requests either load one 64-bit half of the preloaded round-key schedule
// (action 0, key_slot 0..21; higher slots are dropped) or encrypt/decrypt one
// 128-bit block (action 1/2). Action 3 is dropped. A block request runs the
// initial key add, then the rounds one after another through a single shared
// round unit (S-box, shift rows, mix columns except in the last round, key
// add), ten rounds in all. The engine is not ready while a block is in
// flight or while its result waits in the output register. Round keys must
// be loaded before use.
`default_nettype none
module aes128_block_cipher
  import aes128_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [4:0]  in_key_slot,
  input  wire logic [63:0] in_key_word,
  input  wire logic [63:0] in_block_hi,
  input  wire logic [63:0] in_block_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_hi,
  output logic [63:0]      out_result_lo,
  output logic             out_was_decrypt
);

  typedef enum logic [1:0] {ST_IDLE, ST_INIT, ST_RUN, ST_DONE} fsm_t;

  fsm_t             state_r;
  logic [RND_W-1:0] rnd_r;
  logic             dec_r;
  state_t           st_r;
  state_t           blk_r;
  logic [63:0]      key_hi_mem [ROUNDS+1];
  logic [63:0]      key_lo_mem [ROUNDS+1];
  logic [127:0]     rk_r;
  logic [RND_W-1:0] rd_idx;
  state_t           round_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_result_hi   = st_r[127:64];
  assign out_result_lo   = st_r[63:0];
  assign out_was_decrypt = dec_r;

  // key index needed in the next cycle; rnd_r is the round being run
  always_comb begin
    rd_idx = '0;
    case (state_r)
      ST_IDLE: rd_idx = (in_action == ACT_DECRYPT) ? RND_W'(ROUNDS) : '0;
      ST_INIT, ST_RUN: begin
        if (rnd_r == RND_W'(ROUNDS)) rd_idx = '0;
        else rd_idx = dec_r ? RND_W'(ROUNDS - 1) - rnd_r : rnd_r + 1'b1;
      end
      default: rd_idx = '0;
    endcase
  end

  // key memory: two halves, registered read
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_action == ACT_LOAD && in_key_slot < SLOT_W'(KEY_HALVES)) begin
      if (in_key_slot[0]) key_lo_mem[in_key_slot[SLOT_W-1:1]] <= in_key_word;
      else                key_hi_mem[in_key_slot[SLOT_W-1:1]] <= in_key_word;
    end
    rk_r <= {key_hi_mem[rd_idx], key_lo_mem[rd_idx]};
  end

  // shared round unit
  always_comb begin
    if (!dec_r) begin
      round_out = sub_shift(st_r);
      if (rnd_r != RND_W'(ROUNDS)) round_out = mix(round_out);
      round_out = round_out ^ rk_r;
    end else begin
      round_out = inv_shift_sub(st_r) ^ rk_r;
      if (rnd_r != RND_W'(ROUNDS)) round_out = inv_mix(round_out);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_action == ACT_ENCRYPT || in_action == ACT_DECRYPT)) begin
            state_r <= ST_INIT;
            rnd_r   <= '0;
            dec_r   <= (in_action == ACT_DECRYPT);
            blk_r   <= {in_block_hi, in_block_lo};
          end
        end
        ST_INIT: begin
          // decrypt: key add then inverse mix is folded into the round unit,
          // so the initial step is a plain key add either way
          st_r    <= blk_r ^ rk_r;
          rnd_r   <= RND_W'(1);
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          st_r <= round_out;
          if (rnd_r == RND_W'(ROUNDS)) state_r <= ST_DONE;
          else rnd_r <= rnd_r + 1'b1;
        end
        ST_DONE: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
